// File: rtl/mlqs_pkg.sv
// shared types, constants and helpers of the multilevel queue scheduler
`timescale 1ns / 1ps
`default_nettype none
package mlqs_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 64;
  localparam int NUM_QUEUES  = 4;
  localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W      = 2 + SLOT_W;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CNT_W:0]    sum_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam cnt_t DEPTH_CNT = cnt_t'(QUEUE_DEPTH);
  localparam sum_t DEPTH_SUM = sum_t'(QUEUE_DEPTH);

  // operation codes
  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  // status codes
  localparam logic [2:0] STS_DISPATCHED = 3'd0;
  localparam logic [2:0] STS_IDLE       = 3'd1;
  localparam logic [2:0] STS_LOADED     = 3'd2;
  localparam logic [2:0] STS_FULL       = 3'd3;
  localparam logic [2:0] STS_BAD_PRIO   = 3'd4;

  // cpu numbers
  localparam logic [1:0] CPU_FIRST  = 2'd1;
  localparam logic [1:0] CPU_SECOND = 2'd2;

  // queue numbers
  localparam logic [1:0] Q_FCFS = 2'd0;

  // register indexes
  localparam logic REG_QUANTUM2 = 1'b0;
  localparam logic REG_QUANTUM3 = 1'b1;

  localparam logic [15:0] QUANTUM2_RESET = 16'd8;
  localparam logic [15:0] QUANTUM3_RESET = 16'd16;

  typedef struct packed {
    logic        operation;
    logic [31:0] process_id;
    logic [15:0] arrival_key;
    logic [3:0]  priority_req;
    logic [15:0] burst_len;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_process_id;
    logic [1:0]  queue_number;
    logic [1:0]  cpu_number;
    logic [15:0] run_time;
    logic        finished;
  } rsp_t;

  // one stored process
  typedef struct packed {
    logic [15:0] remaining;
    logic [15:0] arrival;
    logic [31:0] id;
  } entry_t;

  typedef struct packed {
    logic   re;
    addr_t  raddr;
    logic   we;
    addr_t  waddr;
    entry_t wdata;
  } mem_req_t;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
  } alu_op_t;

  typedef struct packed {
    logic        borrow;
    logic        zero;
    logic [15:0] diff;
  } alu_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT,
    S_RR_EVAL,
    S_DONE
  } state_t;

  // ring slot arithmetic, operands below twice the depth
  function automatic slot_t slot_wrap(input sum_t sum);
    sum_t r;
    r = (sum >= DEPTH_SUM) ? sum - DEPTH_SUM : sum;
    return r[SLOT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/mlqs_alu.sv
// shared subtract and compare unit
`timescale 1ns / 1ps
`default_nettype none
module mlqs_alu (
  input  mlqs_pkg::alu_op_t  op,
  output mlqs_pkg::alu_res_t res
);

  logic [16:0] full_diff;

  // a minus b with borrow out
  assign full_diff  = {1'b0, op.a} - {1'b0, op.b};
  assign res.borrow = full_diff[16];
  assign res.diff   = full_diff[15:0];
  assign res.zero   = (full_diff[15:0] == 16'd0);

endmodule
`default_nettype wire

// File: rtl/mlqs_store.sv
// process entry memory, one write and one registered read per cycle
`timescale 1ns / 1ps
`default_nettype none
module mlqs_store (
  input  logic                clk,
  input  mlqs_pkg::mem_req_t  req,
  output mlqs_pkg::entry_t    rdata
);

  localparam int ENTRIES = 2 ** mlqs_pkg::ADDR_W;

  mlqs_pkg::entry_t mem [ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/mlqs_ctrl.sv
// scheduling sequencer: queue bookkeeping, minimum scan, compaction and round robin
`timescale 1ns / 1ps
`default_nettype none
module mlqs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  mlqs_pkg::req_t     req,
  input  logic [15:0]        quantum2,
  input  logic [15:0]        quantum3,
  output logic               res_valid,
  input  logic               res_take,
  output mlqs_pkg::rsp_t     res,
  output mlqs_pkg::mem_req_t mem_req,
  input  mlqs_pkg::entry_t   mem_rdata,
  output mlqs_pkg::alu_op_t  alu_op,
  input  mlqs_pkg::alu_res_t alu_res
);

  mlqs_pkg::state_t state, state_next;

  mlqs_pkg::req_t   item;
  mlqs_pkg::cnt_t   counts [mlqs_pkg::NUM_QUEUES];
  mlqs_pkg::slot_t  heads [2];
  logic [1:0]       q;
  mlqs_pkg::cnt_t   n_cur;
  mlqs_pkg::cnt_t   rd_idx;
  logic             pend;
  mlqs_pkg::slot_t  pend_idx;
  mlqs_pkg::slot_t  best;
  logic [15:0]      bkey;
  mlqs_pkg::entry_t best_ent;
  mlqs_pkg::rsp_t   res_reg;

  // decode helpers
  logic            prio_ok;
  logic [1:0]      prio_q;
  logic            prio_full;
  mlqs_pkg::slot_t load_slot;
  logic [1:0]      sel_q;
  logic            any_q;
  logic [2:0]      dec_status;
  logic            issue;
  logic            scan_last;
  logic            take_new;
  mlqs_pkg::slot_t best_upd;
  mlqs_pkg::entry_t best_ent_upd;
  logic [15:0]     key;
  logic [15:0]     quant;
  logic            rr_fit;
  mlqs_pkg::slot_t cur_head;

  assign prio_ok   = (item.priority_req[3:2] == 2'b00);
  assign prio_q    = item.priority_req[1:0];
  assign prio_full = (counts[prio_q] == mlqs_pkg::DEPTH_CNT);
  assign load_slot = prio_q[1]
                   ? mlqs_pkg::slot_wrap(mlqs_pkg::sum_t'(heads[prio_q[0]]) +
                                         mlqs_pkg::sum_t'(counts[prio_q]))
                   : counts[prio_q][mlqs_pkg::SLOT_W-1:0];

  // first queue holding work
  always_comb begin
    sel_q = 2'd0;
    any_q = 1'b0;
    for (int i = mlqs_pkg::NUM_QUEUES - 1; i >= 0; i--) begin
      if (counts[i] != '0) begin
        sel_q = 2'(i);
        any_q = 1'b1;
      end
    end
  end

  // status decided at decode
  always_comb begin
    if (item.operation == mlqs_pkg::OP_LOAD) begin
      if (!prio_ok) begin
        dec_status = mlqs_pkg::STS_BAD_PRIO;
      end else if (prio_full) begin
        dec_status = mlqs_pkg::STS_FULL;
      end else begin
        dec_status = mlqs_pkg::STS_LOADED;
      end
    end else if (!any_q) begin
      dec_status = mlqs_pkg::STS_IDLE;
    end else begin
      dec_status = mlqs_pkg::STS_DISPATCHED;
    end
  end

  // scan and shift stream helpers
  assign issue     = (rd_idx < n_cur);
  assign scan_last = pend &&
                     (mlqs_pkg::cnt_t'(pend_idx) + mlqs_pkg::cnt_t'(1) == n_cur);
  assign key       = (q == mlqs_pkg::Q_FCFS) ? mem_rdata.arrival : mem_rdata.remaining;
  assign take_new  = pend && ((pend_idx == '0) || alu_res.borrow);
  assign best_upd     = take_new ? pend_idx : best;
  assign best_ent_upd = take_new ? mem_rdata : best_ent;

  // round robin helpers
  assign cur_head = heads[q[0]];
  assign quant    = q[0] ? quantum3 : quantum2;
  assign rr_fit   = alu_res.borrow || alu_res.zero;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mlqs_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = mlqs_pkg::S_DECODE;
        end
      end
      mlqs_pkg::S_DECODE: begin
        if (item.operation == mlqs_pkg::OP_LOAD || !any_q) begin
          state_next = mlqs_pkg::S_DONE;
        end else if (sel_q[1]) begin
          state_next = mlqs_pkg::S_RR_EVAL;
        end else begin
          state_next = mlqs_pkg::S_SCAN;
        end
      end
      mlqs_pkg::S_SCAN: begin
        if (scan_last) begin
          if (mlqs_pkg::cnt_t'(best_upd) + mlqs_pkg::cnt_t'(1) == n_cur) begin
            state_next = mlqs_pkg::S_DONE;
          end else begin
            state_next = mlqs_pkg::S_SHIFT;
          end
        end
      end
      mlqs_pkg::S_SHIFT: begin
        if (scan_last) begin
          state_next = mlqs_pkg::S_DONE;
        end
      end
      mlqs_pkg::S_RR_EVAL: begin
        state_next = mlqs_pkg::S_DONE;
      end
      mlqs_pkg::S_DONE: begin
        if (res_take) begin
          state_next = mlqs_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mlqs_pkg::S_IDLE;
      end
    endcase
  end

  // memory and alu control
  always_comb begin
    mem_req       = '0;
    alu_op        = '0;
    req_ready     = 1'b0;
    res_valid     = 1'b0;
    case (state)
      mlqs_pkg::S_IDLE: begin
        req_ready = 1'b1;
      end
      mlqs_pkg::S_DECODE: begin
        if (item.operation == mlqs_pkg::OP_LOAD) begin
          mem_req.we    = prio_ok && !prio_full;
          mem_req.waddr = {prio_q, load_slot};
          mem_req.wdata = '{remaining: item.burst_len, arrival: item.arrival_key,
                            id: item.process_id};
        end else begin
          mem_req.re    = any_q && sel_q[1];
          mem_req.raddr = {sel_q, heads[sel_q[0]]};
        end
      end
      mlqs_pkg::S_SCAN: begin
        mem_req.re    = issue;
        mem_req.raddr = {q, rd_idx[mlqs_pkg::SLOT_W-1:0]};
        alu_op.a      = key;
        alu_op.b      = bkey;
      end
      mlqs_pkg::S_SHIFT: begin
        mem_req.re    = issue;
        mem_req.raddr = {q, rd_idx[mlqs_pkg::SLOT_W-1:0]};
        mem_req.we    = pend;
        mem_req.waddr = {q, pend_idx - mlqs_pkg::slot_t'(1)};
        mem_req.wdata = mem_rdata;
      end
      mlqs_pkg::S_RR_EVAL: begin
        alu_op.a      = mem_rdata.remaining;
        alu_op.b      = quant;
        mem_req.we    = !rr_fit;
        mem_req.waddr = {q, mlqs_pkg::slot_wrap(mlqs_pkg::sum_t'(cur_head) +
                                                mlqs_pkg::sum_t'(n_cur))};
        mem_req.wdata = '{remaining: alu_res.diff, arrival: mem_rdata.arrival,
                          id: mem_rdata.id};
      end
      mlqs_pkg::S_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res = res_reg;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mlqs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // queue bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mlqs_pkg::NUM_QUEUES; i++) begin
        counts[i] <= '0;
      end
      heads[0] <= '0;
      heads[1] <= '0;
      pend     <= 1'b0;
    end else begin
      case (state)
        mlqs_pkg::S_DECODE: begin
          pend <= 1'b0;
          if (item.operation == mlqs_pkg::OP_LOAD) begin
            if (prio_ok && !prio_full) begin
              counts[prio_q] <= counts[prio_q] + mlqs_pkg::cnt_t'(1);
            end
          end
        end
        mlqs_pkg::S_SCAN: begin
          pend <= issue && !scan_last;
          if (scan_last) begin
            counts[q] <= n_cur - mlqs_pkg::cnt_t'(1);
          end
        end
        mlqs_pkg::S_SHIFT: begin
          pend <= issue;
        end
        mlqs_pkg::S_RR_EVAL: begin
          heads[q[0]] <= mlqs_pkg::slot_wrap(mlqs_pkg::sum_t'(cur_head) +
                                             mlqs_pkg::sum_t'(1));
          if (rr_fit) begin
            counts[q] <= n_cur - mlqs_pkg::cnt_t'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // working registers and result
  always_ff @(posedge clk) begin
    case (state)
      mlqs_pkg::S_IDLE: begin
        if (req_valid) begin
          item <= req;
        end
      end
      mlqs_pkg::S_DECODE: begin
        q       <= sel_q;
        n_cur   <= counts[sel_q];
        rd_idx  <= '0;
        res_reg <= '{status: dec_status, out_process_id: 32'd0, queue_number: 2'd0,
                     cpu_number: 2'd0, run_time: 16'd0, finished: 1'b0};
      end
      mlqs_pkg::S_SCAN: begin
        pend_idx <= rd_idx[mlqs_pkg::SLOT_W-1:0];
        best     <= best_upd;
        best_ent <= best_ent_upd;
        if (take_new) begin
          bkey <= key;
        end
        if (scan_last) begin
          rd_idx <= mlqs_pkg::cnt_t'(best_upd) + mlqs_pkg::cnt_t'(1);
          res_reg.status         <= mlqs_pkg::STS_DISPATCHED;
          res_reg.out_process_id <= best_ent_upd.id;
          res_reg.queue_number   <= q;
          res_reg.cpu_number     <= (q == mlqs_pkg::Q_FCFS) ? mlqs_pkg::CPU_FIRST
                                                             : mlqs_pkg::CPU_SECOND;
          res_reg.run_time       <= best_ent_upd.remaining;
          res_reg.finished       <= 1'b1;
        end else begin
          rd_idx <= rd_idx + mlqs_pkg::cnt_t'(issue);
        end
      end
      mlqs_pkg::S_SHIFT: begin
        pend_idx <= rd_idx[mlqs_pkg::SLOT_W-1:0];
        rd_idx   <= rd_idx + mlqs_pkg::cnt_t'(issue);
      end
      mlqs_pkg::S_RR_EVAL: begin
        res_reg.status         <= mlqs_pkg::STS_DISPATCHED;
        res_reg.out_process_id <= mem_rdata.id;
        res_reg.queue_number   <= q;
        res_reg.cpu_number     <= mlqs_pkg::CPU_SECOND;
        res_reg.run_time       <= rr_fit ? mem_rdata.remaining : quant;
        res_reg.finished       <= rr_fit;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/multilevel_queue_scheduler.sv
// top level: register port, result register and the scheduler core
`timescale 1ns / 1ps
`default_nettype none
// Multilevel queue scheduler with four queues served in strict order: queue 0 first come
// first served, queue 1 shortest job first, queues 2 and 3 round robin with their own
// quantum. One item is handled at a time and req_ready is low while it is worked on.
// A load and an idle dispatch go from decode straight to the result, a round robin dispatch
// passes through its evaluation state first. A dispatch from queue 0 or 1 runs the minimum
// scan and then, unless the chosen entry is the last, closes the gap in the queue; queues
// hold 64 entries. The scan is paced by the single read port of the entry memory, which
// gives one entry per cycle to the one shared compare unit. No clearing pass after reset.
// The result register lets the next item be taken while a result waits to be transferred.
module multilevel_queue_scheduler (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  mlqs_pkg::req_t      req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output mlqs_pkg::rsp_t      rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [15:0]        quantum2;
  logic [15:0]        quantum3;
  logic               res_valid;
  logic               res_take;
  mlqs_pkg::rsp_t     res;
  mlqs_pkg::mem_req_t mem_req;
  mlqs_pkg::entry_t   mem_rdata;
  mlqs_pkg::alu_op_t  alu_op;
  mlqs_pkg::alu_res_t alu_res;

  // register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum2 <= mlqs_pkg::QUANTUM2_RESET;
      quantum3 <= mlqs_pkg::QUANTUM3_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == mlqs_pkg::REG_QUANTUM2) begin
        quantum2 <= pwdata[15:0];
      end else begin
        quantum3 <= pwdata[15:0];
      end
    end
  end

  assign prdata = (paddr[2] == mlqs_pkg::REG_QUANTUM3) ? {16'd0, quantum3}
                                                      : {16'd0, quantum2};

  // result register
  assign res_take = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      rsp <= res;
    end
  end

  mlqs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .quantum2  (quantum2),
    .quantum3  (quantum3),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .alu_op    (alu_op),
    .alu_res   (alu_res)
  );

  mlqs_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  mlqs_alu u_alu (
    .op  (alu_op),
    .res (alu_res)
  );

endmodule
`default_nettype wire
